// ----- design/assert_macros.svh -----
// assertion helpers for the hash core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock unless in reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// property checked during reset too
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- design/sk256_pkg.sv -----
package sk256_pkg;

   localparam logic [63:0] KS_PARITY = 64'h1BD11BDAA9FC1A22;
   localparam logic [5:0]  UBI_MSG   = 6'd48;
   localparam logic [5:0]  UBI_OUT   = 6'd63;
   localparam logic [5:0]  BLOCK_BYTES = 6'd32;

   typedef logic [63:0] word_type;
   typedef word_type [3:0] block_type;

   localparam block_type IV = '{64'h6A54E920FDE8DA69, 64'hB33BC3896656840F,
                                64'h2FCA66479FA7D833, 64'hFC9DA860D048B449};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ABSORB,
      ST_MSG,
      ST_FINAL,
      ST_OUT,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;       // capture the input item
      logic take;       // pack held bytes into the block
      logic start_msg;  // compress full buffer, not final
      logic start_fin;  // compress padded buffer, final
      logic start_out;  // compress output block
      logic emit_next;  // advance output word
      logic restart;    // back to iv
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic busy;       // cipher running
      logic full;       // block buffer holds 32 bytes
      logic more;       // bytes of the held item still to pack
   } stat_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
      logic [127:0] d;
      d = {x, x} << r;
      return d[127:64];
   endfunction

   function automatic logic [5:0] rot_a(input logic [2:0] d);
      case (d)
         3'd0: return 6'd14; 3'd1: return 6'd52; 3'd2: return 6'd23; 3'd3: return 6'd5;
         3'd4: return 6'd25; 3'd5: return 6'd46; 3'd6: return 6'd58; default: return 6'd32;
      endcase
   endfunction

   function automatic logic [5:0] rot_b(input logic [2:0] d);
      case (d)
         3'd0: return 6'd16; 3'd1: return 6'd57; 3'd2: return 6'd40; 3'd3: return 6'd37;
         3'd4: return 6'd33; 3'd5: return 6'd12; 3'd6: return 6'd22; default: return 6'd32;
      endcase
   endfunction

endpackage

// ----- design/sk256_ctrl.sv -----
module sk256_ctrl
   import sk256_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_last,
   input  logic     rsp_ready,
   output logic     rsp_valid,
   output logic     rsp_last_word,
   input  logic [1:0] word_idx,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      last_ff, last_in;

   // next state
   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               last_in  = req_last;
               state_in = ST_ABSORB;
            end
         end
         ST_ABSORB: begin
            if (stat.more) begin
               if (stat.full) state_in = ST_MSG;
            end else if (last_ff) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MSG:   if (!stat.busy) state_in = ST_ABSORB;
         ST_FINAL: if (!stat.busy) state_in = ST_OUT;
         ST_OUT:   if (!stat.busy) state_in = ST_EMIT;
         ST_EMIT:  if (rsp_ready && word_idx == 2'd3) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_ABSORB: begin
            cmd.take      = stat.more && !stat.full;
            cmd.start_msg = stat.more && stat.full;
            cmd.start_fin = !stat.more && last_ff;
         end
         ST_MSG:   ;
         ST_FINAL: cmd.start_out = !stat.busy;
         ST_OUT:   ;
         ST_EMIT: begin
            rsp_valid     = 1'b1;
            cmd.emit_next = rsp_ready;
            cmd.restart   = rsp_ready && word_idx == 2'd3;
         end
         default: ;
      endcase
   end
   assign rsp_last_word = word_idx == 2'd3;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ----- design/sk256_dp.sv -----
module sk256_dp
   import sk256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_bytes_valid,
   input  cmd_type     cmd,
   output stat_type    stat,
   output logic [63:0] digest,
   output logic [1:0]  word_idx
);

   block_type  cv_ff, cv_in, msg_ff, msg_in, x_ff, x_in, pl_ff, pl_in, key_ff, key_in;
   logic [63:0] k4_ff, k4_in, t0_ff, t0_in, t1_ff, t1_in, cnt_ff, cnt_in;
   logic [5:0]  fill_ff, fill_in;
   logic [4:0]  sub_ff, sub_in;
   // round group count modulo five and modulo three
   logic [2:0]  ks_ff, ks_in;
   logic [1:0]  ts_ff, ts_in;
   logic        busy_ff, busy_in;
   logic [1:0]  widx_ff, widx_in;
   // pending bytes of the held item
   logic [63:0] pw_ff, pw_in;
   logic [3:0]  pn_ff, pn_in;
   logic [63:0] fin_pos;

   // per-byte append of up to eight bytes into the block
   logic [3:0]  n_sat;
   logic [3:0]  room, take_n;
   logic [5:0]  bpos;
   block_type   msg_app;
   logic [5:0]  fill_app;

   always_comb begin
      n_sat = (req_bytes_valid > 4'd8) ? 4'd8 : req_bytes_valid;
      room  = (BLOCK_BYTES - fill_ff > 6'd8) ? 4'd8 : 4'(BLOCK_BYTES - fill_ff);
      take_n = (pn_ff < room) ? pn_ff : room;
      msg_app = msg_ff;
      bpos = fill_ff;
      for (int i = 0; i < 8; i++) begin
         bpos = fill_ff + 6'(i);
         if (4'(i) < take_n)
            msg_app[bpos[4:3]][{bpos[2:0], 3'b000} +: 8] = pw_ff[i*8 +: 8];
      end
      fill_app = fill_ff + 6'(take_n);
   end

   // subkey schedule for the current injection
   function automatic logic [63:0] kx(input block_type k, input logic [63:0] k4,
                                      input logic [2:0] ks, input logic [2:0] j);
      logic [2:0] m;
      m = ks + j;
      if (m >= 3'd5) m = m - 3'd5;
      return (m == 3'd4) ? k4 : k[m[1:0]];
   endfunction
   function automatic logic [63:0] tx(input logic [63:0] a, input logic [63:0] b,
                                      input logic [1:0] ts, input logic [1:0] j);
      logic [1:0] m;
      m = ts + j;
      if (m >= 2'd3) m = m - 2'd3;
      return (m == 2'd0) ? a : (m == 2'd1) ? b : a ^ b;
   endfunction

   block_type inj, rnd;
   always_comb begin
      inj[0] = x_ff[0] + kx(key_ff, k4_ff, ks_ff, 3'd0);
      inj[1] = x_ff[1] + kx(key_ff, k4_ff, ks_ff, 3'd1) + tx(t0_ff, t1_ff, ts_ff, 2'd0);
      inj[2] = x_ff[2] + kx(key_ff, k4_ff, ks_ff, 3'd2) + tx(t0_ff, t1_ff, ts_ff, 2'd1);
      inj[3] = x_ff[3] + kx(key_ff, k4_ff, ks_ff, 3'd3) + 64'(sub_ff);
      rnd = inj;
      for (int r = 0; r < 4; r++) begin
         logic [63:0] tmp;
         logic [2:0]  d;
         d = {sub_ff[0], 2'(r)};
         rnd[0] = rnd[0] + rnd[1];
         rnd[1] = rotl(rnd[1], rot_a(d)) ^ rnd[0];
         rnd[2] = rnd[2] + rnd[3];
         rnd[3] = rotl(rnd[3], rot_b(d)) ^ rnd[2];
         tmp = rnd[1]; rnd[1] = rnd[3]; rnd[3] = tmp;
      end
   end

   function automatic logic [63:0] par(input block_type k);
      return KS_PARITY ^ k[0] ^ k[1] ^ k[2] ^ k[3];
   endfunction

   always_comb begin
      cv_in = cv_ff; msg_in = msg_ff; x_in = x_ff; pl_in = pl_ff; key_in = key_ff;
      k4_in = k4_ff; t0_in = t0_ff; t1_in = t1_ff; cnt_in = cnt_ff; fill_in = fill_ff;
      sub_in = sub_ff; busy_in = busy_ff; widx_in = widx_ff; pw_in = pw_ff; pn_in = pn_ff;
      ks_in = ks_ff; ts_in = ts_ff;
      fin_pos = cnt_ff + 64'(fill_ff);
      // cipher stepping, four rounds per cycle
      if (busy_ff) begin
         sub_in = sub_ff + 5'd1;
         ks_in  = (ks_ff == 3'd4) ? 3'd0 : ks_ff + 3'd1;
         ts_in  = (ts_ff == 2'd2) ? 2'd0 : ts_ff + 2'd1;
         if (sub_ff == 5'd18) begin
            busy_in = 1'b0;
            for (int i = 0; i < 4; i++) cv_in[i] = inj[i] ^ pl_ff[i];
         end else begin
            x_in = rnd;
         end
      end
      // hold the accepted item
      if (cmd.load) begin
         pw_in = req_data_word;
         pn_in = n_sat;
      end
      // absorb bytes
      if (cmd.take) begin
         msg_in  = msg_app;
         fill_in = fill_app;
         pw_in   = pw_ff >> {take_n, 3'b000};
         pn_in   = pn_ff - take_n;
      end
      if (cmd.start_msg) begin
         cnt_in = cnt_ff + 64'd32;
         key_in = cv_ff; k4_in = par(cv_ff);
         x_in = msg_ff; pl_in = msg_ff;
         t0_in = cnt_ff + 64'd32;
         t1_in = {1'b0, (cnt_ff + 64'd32) <= 64'd32, UBI_MSG, 56'd0};
         sub_in = '0; ks_in = '0; ts_in = '0; busy_in = 1'b1;
         msg_in = '0; fill_in = '0;
      end
      if (cmd.start_fin) begin
         key_in = cv_ff; k4_in = par(cv_ff);
         x_in = msg_ff; pl_in = msg_ff;
         t0_in = fin_pos;
         t1_in = {1'b1, fin_pos <= 64'd32, UBI_MSG, 56'd0};
         sub_in = '0; ks_in = '0; ts_in = '0; busy_in = 1'b1;
      end
      if (cmd.start_out) begin
         key_in = cv_ff; k4_in = par(cv_ff);
         x_in = '0; pl_in = '0;
         t0_in = 64'd8;
         t1_in = {2'b11, UBI_OUT, 56'd0};
         sub_in = '0; ks_in = '0; ts_in = '0; busy_in = 1'b1;
      end
      if (cmd.emit_next) widx_in = widx_ff + 2'd1;
      if (cmd.restart) begin
         cv_in = IV; msg_in = '0; fill_in = '0; cnt_in = '0; widx_in = '0; pn_in = '0;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.more = pn_ff != 4'd0;
   assign stat.full = fill_ff == BLOCK_BYTES;
   assign digest   = cv_ff[widx_ff];
   assign word_idx = widx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= IV; msg_ff <= '0; fill_ff <= '0; cnt_ff <= '0;
         busy_ff <= 1'b0; widx_ff <= '0; pn_ff <= '0; sub_ff <= '0;
         ks_ff <= '0; ts_ff <= '0;
      end else begin
         cv_ff <= cv_in; msg_ff <= msg_in; fill_ff <= fill_in; cnt_ff <= cnt_in;
         busy_ff <= busy_in; widx_ff <= widx_in; pn_ff <= pn_in; sub_ff <= sub_in;
         ks_ff <= ks_in; ts_ff <= ts_in;
      end
      x_ff <= x_in; pl_ff <= pl_in; key_ff <= key_in; k4_ff <= k4_in;
      t0_ff <= t0_in; t1_ff <= t1_in; pw_ff <= pw_in;
   end

endmodule

// ----- design/skein256_hash_core.sv -----
// Skein-256-256 hash core. Message bytes arrive up to eight per item, little-endian,
// and are packed into a 32-byte block. A full block is compressed once more bytes
// follow it; an item with last set compresses the padded final block and then the
// output block, and four 64-bit digest words leave on the rsp channel, word 0 first.
// Each compression runs Threefish-256 at four rounds per cycle on one round unit.
// An item is taken in the idle state and packed in the absorb state; no new item is
// taken until it is packed, and a word split across two blocks waits for the full
// block to be compressed. After the last item the final and output blocks are
// compressed, then the digest words go out one per cycle while rsp_ready is high.
module skein256_hash_core
   import sk256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_bytes_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);
`include "assert_macros.svh"

   cmd_type  cmd;
   stat_type stat;
   logic [1:0] widx;

   sk256_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_last, .rsp_ready, .rsp_valid,
      .rsp_last_word, .word_idx(widx), .stat, .cmd
   );

   sk256_dp u_dp (
      .clock, .reset, .req_data_word, .req_bytes_valid, .cmd, .stat,
      .digest(rsp_digest_word), .word_idx(widx)
   );

   assign rsp_word_index = widx;

   // no input taken while results are shown
   `ASSERT_CLK(a_no_overlap, !(rsp_valid && req_ready), "input accepted during output")
   // output never shown while cipher runs
   `ASSERT_CLK(a_idle_out, rsp_valid |-> !stat.busy, "output during compression")
   // word index restarts after the last word
   `ASSERT_CLK(a_wrap, (rsp_valid && rsp_ready && rsp_last_word) |=> rsp_word_index == 2'd0,
               "word index not restarted")

endmodule
